### hw/rtl/bearing_angle_from_points_top_assert.svh
// Assertion helpers for the bearing block; clk and rst_n are taken from the enclosing module.
`ifndef BEARING_ANGLE_FROM_POINTS_TOP_ASSERT_SVH
`define BEARING_ANGLE_FROM_POINTS_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BAFP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bafp: same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define BAFP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bafp: next-cycle check failed");

`endif

### hw/rtl/bafp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bafp_pkg;

    localparam int CoordFracBits = 16;
    localparam int AngleFracBits = 16;
    localparam int CordicSteps   = 24;

    localparam int MarginW     = 16;
    localparam int PerMille    = 1000;
    localparam logic [MarginW-1:0] MarginReset =
        MarginW'(((1 << CoordFracBits) + PerMille / 2) / PerMille);

    localparam int DiffW     = 33;
    localparam int NormW     = 40;
    localparam int NormSteps = 6;
    localparam int CordicW   = 43;
    localparam int AccW      = 48;
    localparam int AccFrac   = 40;

    localparam logic [63:0] RadToDegQ40 = 64'd62997375797126;
    localparam logic signed [AccW-1:0] Deg45 = AccW'(45) << AccFrac;
    localparam logic signed [AccW-1:0] Deg90 = AccW'(90) << AccFrac;

    typedef enum logic [2:0] {
        CLS_EAST,
        CLS_NORTH,
        CLS_WEST,
        CLS_SOUTH,
        CLS_CORDIC
    } bafp_class_t;

    typedef struct packed {
        bafp_class_t cls;
        logic        dx_neg;
        logic        dy_neg;
    } bafp_tag_t;

    // atan(2^-idx) in degrees, Q40, by the arctangent series
    function automatic logic signed [AccW-1:0] step_angle(input int idx);
        logic [63:0] s;
        s = 64'd0;
        if (idx == 0)
        begin
            s = 64'(Deg45);
        end
        else
        begin
            s = s + ((RadToDegQ40 >> (idx * 1)) / 1);
            s = s - ((RadToDegQ40 >> (idx * 3)) / 3);
            s = s + ((RadToDegQ40 >> (idx * 5)) / 5);
            s = s - ((RadToDegQ40 >> (idx * 7)) / 7);
            s = s + ((RadToDegQ40 >> (idx * 9)) / 9);
            s = s - ((RadToDegQ40 >> (idx * 11)) / 11);
            s = s + ((RadToDegQ40 >> (idx * 13)) / 13);
            s = s - ((RadToDegQ40 >> (idx * 15)) / 15);
            s = s + ((RadToDegQ40 >> (idx * 17)) / 17);
            s = s - ((RadToDegQ40 >> (idx * 19)) / 19);
            s = s + ((RadToDegQ40 >> (idx * 21)) / 21);
            s = s - ((RadToDegQ40 >> (idx * 23)) / 23);
            s = s + ((RadToDegQ40 >> (idx * 25)) / 25);
            s = s - ((RadToDegQ40 >> (idx * 27)) / 27);
            s = s + ((RadToDegQ40 >> (idx * 29)) / 29);
            s = s - ((RadToDegQ40 >> (idx * 31)) / 31);
            s = s + ((RadToDegQ40 >> (idx * 33)) / 33);
            s = s - ((RadToDegQ40 >> (idx * 35)) / 35);
            s = s + ((RadToDegQ40 >> (idx * 37)) / 37);
            s = s - ((RadToDegQ40 >> (idx * 39)) / 39);
            s = s + ((RadToDegQ40 >> (idx * 41)) / 41);
            s = s - ((RadToDegQ40 >> (idx * 43)) / 43);
            s = s + ((RadToDegQ40 >> (idx * 45)) / 45);
            s = s - ((RadToDegQ40 >> (idx * 47)) / 47);
            s = s + ((RadToDegQ40 >> (idx * 49)) / 49);
            s = s - ((RadToDegQ40 >> (idx * 51)) / 51);
            s = s + ((RadToDegQ40 >> (idx * 53)) / 53);
            s = s - ((RadToDegQ40 >> (idx * 55)) / 55);
            s = s + ((RadToDegQ40 >> (idx * 57)) / 57);
            s = s - ((RadToDegQ40 >> (idx * 59)) / 59);
            s = s + ((RadToDegQ40 >> (idx * 61)) / 61);
            s = s - ((RadToDegQ40 >> (idx * 63)) / 63);
        end
        return $signed(s[AccW-1:0]);
    endfunction

endpackage
`default_nettype wire

### hw/rtl/bafp_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module bafp_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bafp_pkg::MarginW-1:0]  margin,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [31:0]            from_x,
    input  logic signed [31:0]            from_y,
    input  logic signed [31:0]            to_x,
    input  logic signed [31:0]            to_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bafp_pkg::NormW-1:0]    ax,
    output logic [bafp_pkg::NormW-1:0]    ay,
    output bafp_pkg::bafp_tag_t           tag
);
    import bafp_pkg::*;

    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic [DiffW-1:0]        mag_x;
    logic [DiffW-1:0]        mag_y;
    logic                    near_x;
    logic                    near_y;
    logic                    valid_reg;
    logic                    valid_next;
    logic [NormW-1:0]        ax_reg;
    logic [NormW-1:0]        ay_reg;
    bafp_tag_t               tag_reg;
    bafp_tag_t               tag_next;

    always_comb
    begin
        dx     = DiffW'(to_x) - DiffW'(from_x);
        dy     = DiffW'(to_y) - DiffW'(from_y);
        mag_x  = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
        mag_y  = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
        near_x = mag_x < DiffW'(margin);
        near_y = mag_y < DiffW'(margin);

        tag_next.dx_neg = dx[DiffW-1];
        tag_next.dy_neg = dy[DiffW-1];
        if ((near_x && near_y) || (dx == '0 && dy == '0))
        begin
            tag_next.cls = CLS_EAST;
        end
        else if (near_x)
        begin
            tag_next.cls = (!dy[DiffW-1] && dy != '0) ? CLS_NORTH : CLS_SOUTH;
        end
        else if (near_y)
        begin
            tag_next.cls = (!dx[DiffW-1] && dx != '0) ? CLS_EAST : CLS_WEST;
        end
        else
        begin
            tag_next.cls = CLS_CORDIC;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg  <= NormW'(mag_x);
            ay_reg  <= NormW'(mag_y);
            tag_reg <= tag_next;
        end
    end

    assign out_valid = valid_reg;
    assign ax        = ax_reg;
    assign ay        = ay_reg;
    assign tag       = tag_reg;

endmodule
`default_nettype wire

### hw/rtl/bafp_norm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bafp_norm_cell #(
    parameter int SHIFT = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [bafp_pkg::NormW-1:0]  ax_in,
    input  logic [bafp_pkg::NormW-1:0]  ay_in,
    input  bafp_pkg::bafp_tag_t         tag_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bafp_pkg::NormW-1:0]  ax_out,
    output logic [bafp_pkg::NormW-1:0]  ay_out,
    output bafp_pkg::bafp_tag_t         tag_out
);
    import bafp_pkg::*;

    logic             room;
    logic [NormW-1:0] ax_next;
    logic [NormW-1:0] ay_next;
    logic [NormW-1:0] ax_reg;
    logic [NormW-1:0] ay_reg;
    bafp_tag_t        tag_reg;
    logic             valid_reg;
    logic             valid_next;

    // shift both by SHIFT when the top SHIFT bits of the larger magnitude are clear
    always_comb
    begin
        room    = ((ax_in | ay_in) >> (NormW - SHIFT)) == '0;
        ax_next = room ? (ax_in << SHIFT) : ax_in;
        ay_next = room ? (ay_in << SHIFT) : ay_in;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;
            tag_reg <= tag_in;
        end
    end

    assign out_valid = valid_reg;
    assign ax_out    = ax_reg;
    assign ay_out    = ay_reg;
    assign tag_out   = tag_reg;

endmodule
`default_nettype wire

### hw/rtl/bafp_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module bafp_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bafp_pkg::CordicW-1:0] x_in,
    input  logic signed [bafp_pkg::CordicW-1:0] y_in,
    input  logic signed [bafp_pkg::AccW-1:0]    z_in,
    input  bafp_pkg::bafp_tag_t                 tag_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bafp_pkg::CordicW-1:0] x_out,
    output logic signed [bafp_pkg::CordicW-1:0] y_out,
    output logic signed [bafp_pkg::AccW-1:0]    z_out,
    output bafp_pkg::bafp_tag_t                 tag_out
);
    import bafp_pkg::*;

    localparam logic signed [AccW-1:0] Angle = step_angle(IDX);

    logic signed [CordicW-1:0] x_sh;
    logic signed [CordicW-1:0] y_sh;
    logic signed [CordicW-1:0] x_next;
    logic signed [CordicW-1:0] y_next;
    logic signed [AccW-1:0]    z_next;
    logic signed [CordicW-1:0] x_reg;
    logic signed [CordicW-1:0] y_reg;
    logic signed [AccW-1:0]    z_reg;
    bafp_tag_t                 tag_reg;
    logic                      valid_reg;
    logic                      valid_next;

    // rotate towards the x axis
    always_comb
    begin
        x_sh = x_in >>> IDX;
        y_sh = y_in >>> IDX;
        if (!y_in[CordicW-1])
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + Angle;
        end
        else
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - Angle;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign tag_out   = tag_reg;

endmodule
`default_nettype wire

### hw/rtl/bafp_post.sv
`timescale 1ns / 1ps
`default_nettype none
module bafp_post #(
    parameter int ANGLE_FRAC_BITS = bafp_pkg::AngleFracBits
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [bafp_pkg::AccW-1:0] z_in,
    input  bafp_pkg::bafp_tag_t              tag_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ANGLE_FRAC_BITS+8:0]       angle
);
    import bafp_pkg::*;

    localparam int OutW     = ANGLE_FRAC_BITS + 9;
    localparam int DropBits = AccFrac - ANGLE_FRAC_BITS;
    localparam logic [AccW-1:0] RoundBit     = AccW'(1) << (DropBits - 1);
    localparam logic [OutW-1:0] Quarter      = OutW'(90) << ANGLE_FRAC_BITS;
    localparam logic [OutW-1:0] Half         = OutW'(180) << ANGLE_FRAC_BITS;
    localparam logic [OutW-1:0] ThreeQuarter = OutW'(270) << ANGLE_FRAC_BITS;
    localparam logic [OutW-1:0] Full         = OutW'(360) << ANGLE_FRAC_BITS;

    logic [AccW-1:0] z_clamp;
    logic [AccW-1:0] z_round;
    logic [OutW-1:0] q_next;
    logic [OutW-1:0] q_reg;
    bafp_tag_t       tag_reg;
    logic            rnd_valid_reg;
    logic            rnd_valid_next;
    logic            rnd_ready;
    logic [OutW-1:0] angle_next;
    logic [OutW-1:0] angle_reg;
    logic            out_valid_reg;
    logic            out_valid_next;

    // clamp to the first quadrant and round half up
    always_comb
    begin
        if (z_in[AccW-1])
        begin
            z_clamp = '0;
        end
        else if (z_in > Deg90)
        begin
            z_clamp = AccW'(Deg90);
        end
        else
        begin
            z_clamp = AccW'(z_in);
        end
        z_round = z_clamp + RoundBit;
        q_next  = OutW'(z_round >> DropBits);
    end

    // map back to the quadrant of the difference vector; axis classes get a fixed angle
    always_comb
    begin
        case (tag_reg.cls)
            CLS_EAST:  angle_next = '0;
            CLS_NORTH: angle_next = Quarter;
            CLS_WEST:  angle_next = Half;
            CLS_SOUTH: angle_next = ThreeQuarter;
            CLS_CORDIC:
            begin
                if (!tag_reg.dx_neg)
                begin
                    if (!tag_reg.dy_neg)
                    begin
                        angle_next = q_reg;
                    end
                    else
                    begin
                        angle_next = (q_reg == '0) ? '0 : Full - q_reg;
                    end
                end
                else
                begin
                    angle_next = tag_reg.dy_neg ? Half + q_reg : Half - q_reg;
                end
            end
            default:   angle_next = '0;
        endcase
    end

    assign rnd_ready      = !out_valid_reg || out_ready;
    assign in_ready       = !rnd_valid_reg || rnd_ready;
    assign rnd_valid_next = in_ready ? in_valid : rnd_valid_reg;
    assign out_valid_next = rnd_ready ? rnd_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rnd_valid_reg <= rnd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            q_reg   <= q_next;
            tag_reg <= tag_in;
        end
        if (rnd_valid_reg && rnd_ready)
        begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign angle     = angle_reg;

endmodule
`default_nettype wire

### hw/rtl/bearing_angle_from_points_top.sv
// A beat passes u_prep, g_norm, g_cordic and then q_reg and angle_reg in u_post.
// Throughput: one beat per cycle while out_stall is low; every normalising step
// and every CORDIC cell is one register stage, with the valid/stall pair running
// through all of them. A stalled output lets upstream bubbles close up before the
// input stalls. Reset clears all stage valid flags and loads margin_reg with 66.
`timescale 1ns / 1ps
`default_nettype none
`include "bearing_angle_from_points_top_assert.svh"
module bearing_angle_from_points_top #(
    parameter int ANGLE_FRAC_BITS = bafp_pkg::AngleFracBits,
    parameter int CORDIC_STEPS    = bafp_pkg::CordicSteps
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bafp_pkg::MarginW-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            from_x,
    input  logic signed [31:0]            from_y,
    input  logic signed [31:0]            to_x,
    input  logic signed [31:0]            to_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ANGLE_FRAC_BITS+8:0]    angle_degrees
);
    import bafp_pkg::*;

    localparam logic [ANGLE_FRAC_BITS+8:0] FullTurn =
        (ANGLE_FRAC_BITS + 9)'(360) << ANGLE_FRAC_BITS;

    logic [MarginW-1:0]        margin_reg;
    logic [MarginW-1:0]        margin_next;
    logic                      prep_ready;

    logic [NormSteps:0]        n_valid;
    logic [NormSteps:0]        n_ready;
    logic [NormW-1:0]          n_ax  [0:NormSteps];
    logic [NormW-1:0]          n_ay  [0:NormSteps];
    bafp_tag_t                 n_tag [0:NormSteps];

    logic [CORDIC_STEPS:0]     c_valid;
    logic [CORDIC_STEPS:0]     c_ready;
    logic signed [CordicW-1:0] c_x   [0:CORDIC_STEPS];
    logic signed [CordicW-1:0] c_y   [0:CORDIC_STEPS];
    logic signed [AccW-1:0]    c_z   [0:CORDIC_STEPS];
    bafp_tag_t                 c_tag [0:CORDIC_STEPS];

    assign cfg_ready   = 1'b1;
    assign margin_next = (cfg_valid && cfg_ready) ? cfg_data : margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MarginReset;
        end
        else
        begin
            margin_reg <= margin_next;
        end
    end

    assign in_stall = !prep_ready;

    bafp_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .margin    (margin_reg),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .out_valid (n_valid[0]),
        .out_ready (n_ready[0]),
        .ax        (n_ax[0]),
        .ay        (n_ay[0]),
        .tag       (n_tag[0])
    );

    for (genvar j = 0; j < NormSteps; j++)
    begin : g_norm
        bafp_norm_cell #(
            .SHIFT (1 << (NormSteps - 1 - j))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (n_valid[j]),
            .in_ready  (n_ready[j]),
            .ax_in     (n_ax[j]),
            .ay_in     (n_ay[j]),
            .tag_in    (n_tag[j]),
            .out_valid (n_valid[j+1]),
            .out_ready (n_ready[j+1]),
            .ax_out    (n_ax[j+1]),
            .ay_out    (n_ay[j+1]),
            .tag_out   (n_tag[j+1])
        );
    end

    assign c_valid[0]         = n_valid[NormSteps];
    assign n_ready[NormSteps] = c_ready[0];
    assign c_x[0]             = $signed(CordicW'(n_ax[NormSteps]));
    assign c_y[0]             = $signed(CordicW'(n_ay[NormSteps]));
    assign c_z[0]             = '0;
    assign c_tag[0]           = n_tag[NormSteps];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        bafp_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .x_in      (c_x[i]),
            .y_in      (c_y[i]),
            .z_in      (c_z[i]),
            .tag_in    (c_tag[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .x_out     (c_x[i+1]),
            .y_out     (c_y[i+1]),
            .z_out     (c_z[i+1]),
            .tag_out   (c_tag[i+1])
        );
    end

    bafp_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid[CORDIC_STEPS]),
        .in_ready  (c_ready[CORDIC_STEPS]),
        .z_in      (c_z[CORDIC_STEPS]),
        .tag_in    (c_tag[CORDIC_STEPS]),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .angle     (angle_degrees)
    );

    `BAFP_ASSERT_NOW(a_angle_range, out_valid, angle_degrees < FullTurn)
    `BAFP_ASSERT_NEXT(a_margin_write, cfg_valid && cfg_ready, margin_reg == $past(cfg_data))
    `BAFP_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, n_valid[0])

endmodule
`default_nettype wire
